>>> rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Field widths, arithmetic constants, register indices and shared types for
// the multi-channel echo pulse ranger.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int LEVEL_W    = 6;
    localparam int TIME_W     = 16;
    localparam int CHAN_W     = 3;
    localparam int DIST_W     = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // Depth of the queue between the edge detector and the result sequencer.
    localparam int QUEUE_DEPTH = 4;

    // floor(half / 58) is computed as (half * RECIP_MULT) >> RECIP_SHIFT,
    // which is exact for every half-tick count below 2^15.
    localparam int HALF_W      = TIME_W - 1;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = HALF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd72317;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 10'd2;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 10'd400;
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RESET   = 10'd10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_DISTANCE = 2'd0,
        CFG_MAX_DISTANCE = 2'd1,
        CFG_NEAR_LIMIT   = 2'd2
    } mer_cfg_index_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_cm;
        logic [DIST_W-1:0] max_cm;
        logic [DIST_W-1:0] near_cm;
    } mer_cfg_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } mer_queue_status_t;

endpackage

>>> rtl/mer_front.sv
// ----------------------------------------------------------------------------
// Echo ranger front end
// Tracks echo line levels, start times and active flags, and hands each
// transaction's completed channels with their tick counts to the queue.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int CHANNELS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_fire,
    input  logic [mer_pkg::LEVEL_W-1:0]         echo_levels,
    input  logic [mer_pkg::TIME_W-1:0]          timer_now,
    input  logic [mer_pkg::LEVEL_W-1:0]         rearm_mask,
    output logic                                push,
    output logic [CHANNELS-1:0]                 done_mask,
    output logic [CHANNELS*mer_pkg::TIME_W-1:0] ticks_flat
);
    import mer_pkg::*;

    logic [CHANNELS-1:0] prev_levels_reg, prev_levels_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [CHANNELS-1:0] levels, rearm, armed, changed, rising, falling;
    logic [TIME_W-1:0]   start_reg [CHANNELS];

    genvar i;
    generate
        for (i = 0; i < CHANNELS; i++) begin : g_ch
            if (i < LEVEL_W) begin : g_line
                assign levels[i] = echo_levels[i];
                assign rearm[i]  = rearm_mask[i];
            end else begin : g_pad
                assign levels[i] = 1'b0;
                assign rearm[i]  = 1'b0;
            end

            always_ff @(posedge aclk) begin
                if (in_fire && rising[i]) begin
                    start_reg[i] <= timer_now;
                end
            end

            // A wrapped counter gives 65535 - start + end, one less than the
            // modular difference.
            assign ticks_flat[i*TIME_W +: TIME_W] = timer_now - start_reg[i]
                - {{(TIME_W-1){1'b0}}, (timer_now < start_reg[i])};
        end
    endgenerate

    always_comb begin
        armed            = active_reg & ~rearm;
        changed          = levels ^ prev_levels_reg;
        rising           = changed & levels;
        falling          = changed & ~levels & armed;
        active_next      = (armed & ~falling) | rising;
        prev_levels_next = levels;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
            active_reg      <= '0;
        end else if (in_fire) begin
            prev_levels_reg <= prev_levels_next;
            active_reg      <= active_next;
        end
    end

    assign push      = in_fire && (|falling);
    assign done_mask = falling;

endmodule

>>> rtl/mer_queue.sv
// ----------------------------------------------------------------------------
// Echo ranger queue
// Small first-in first-out buffer of completed-channel sets between the
// front end and the result sequencer.
// ----------------------------------------------------------------------------
module mer_queue #(
    parameter int WIDTH = 102,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output mer_pkg::mer_queue_status_t status
);
    import mer_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data        = slot_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == CNT_W'(DEPTH));

endmodule

>>> rtl/mer_back.sv
// ----------------------------------------------------------------------------
// Echo ranger result sequencer
// Walks the completed channels of the queue head in ascending order, converts
// each tick count to centimetres and applies the configured limits.
// ----------------------------------------------------------------------------
module mer_back #(
    parameter int CHANNELS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mer_pkg::mer_cfg_t                   cfg,
    input  logic                                head_valid,
    input  logic [CHANNELS-1:0]                 head_mask,
    input  logic [CHANNELS*mer_pkg::TIME_W-1:0] head_ticks,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mer_pkg::CHAN_W-1:0]          m_channel,
    output logic [mer_pkg::DIST_W-1:0]          m_distance,
    output logic                                m_near,
    output logic                                m_last
);
    import mer_pkg::*;

    logic [CHANNELS-1:0] served_reg, served_next;
    logic [CHANNELS-1:0] pending, lowest;
    logic                sel_last;
    logic [CHAN_W-1:0]   sel_idx;
    logic [TIME_W-1:0]   sel_ticks;
    logic [PROD_W-1:0]   product;
    logic                take, s1_adv, out_adv;

    logic                s1_valid_reg, s1_valid_next;
    logic [CHAN_W-1:0]   s1_chan_reg;
    logic [DIST_W-1:0]   s1_dist_reg;
    logic                s1_last_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [DIST_W-1:0]   out_dist_reg, dist_limited;
    logic                out_near_reg, near_flag;
    logic                out_last_reg;

    always_comb begin
        pending  = head_mask & ~served_reg;
        lowest   = pending & (~pending + CHANNELS'(1));
        sel_last = ((pending & ~lowest) == '0);
        sel_idx   = '0;
        sel_ticks = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (lowest[k]) begin
                sel_idx   = CHAN_W'(k);
                sel_ticks = head_ticks[k*TIME_W +: TIME_W];
            end
        end
        product = {{RECIP_W{1'b0}}, sel_ticks[TIME_W-1:1]}
                * {{HALF_W{1'b0}}, RECIP_MULT};
    end

    assign out_adv = !out_valid_reg || m_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign take    = head_valid && s1_adv;
    assign pop     = take && sel_last;

    always_comb begin
        served_next = served_reg;
        if (take) begin
            served_next = sel_last ? '0 : (served_reg | lowest);
        end
        s1_valid_next  = s1_adv ? take : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_comb begin
        if ((s1_dist_reg >= cfg.min_cm) && (s1_dist_reg <= cfg.max_cm)) begin
            dist_limited = s1_dist_reg;
        end else begin
            dist_limited = '0;
        end
        near_flag = (dist_limited != '0) && (dist_limited <= cfg.near_cm);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            served_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            served_reg    <= served_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_chan_reg <= sel_idx;
            s1_dist_reg <= product[RECIP_SHIFT +: DIST_W];
            s1_last_reg <= sel_last;
        end
        if (out_adv && s1_valid_reg) begin
            out_chan_reg <= s1_chan_reg;
            out_dist_reg <= dist_limited;
            out_near_reg <= near_flag;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_channel  = out_chan_reg;
    assign m_distance = out_dist_reg;
    assign m_near     = out_near_reg;
    assign m_last     = out_last_reg;

endmodule

>>> rtl/multi_echo_pulse_ranger.sv
// ----------------------------------------------------------------------------
// Multi-channel echo pulse ranger
// Measures echo pulse widths on several lines against a free-running tick
// counter and reports each completed measurement as a distance in centimetres.
//
//   Port group  Direction  Carries
//   s_*         in         one sample of echo lines, counter and re-arm mask
//   m_*         out        one completed measurement, tlast on the final one
//   cfg_*       in         writes to the three limit registers
//
// One sample is accepted every cycle while the result queue has room.
// Results leave at one per cycle while m_tready is high, each passing through the queue, s1 and output stages.
// The four-entry queue holds samples with completions while m_tready is low;
// s_tready falls only when it is full.
// Synchronous reset clears the line state, the queue and the output stages.
// ----------------------------------------------------------------------------
module multi_echo_pulse_ranger #(
    parameter int CHANNELS = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: echo_levels[5:0], timer_now[21:6], rearm_mask[27:22], zero pad.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mer_pkg::IN_DATA_W-1:0]        s_tdata,
    // m_tdata: channel[2:0], range_cm[12:3], near[13], zero pad.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mer_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [mer_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [mer_pkg::DIST_W-1:0]           cfg_wdata
);
    import mer_pkg::*;

    localparam int ENTRY_W = CHANNELS * (TIME_W + 1);

    mer_cfg_t            cfg_reg, cfg_next;
    mer_queue_status_t   q_status;
    logic                in_fire, push;
    logic [CHANNELS-1:0] done_mask;
    logic [CHANNELS*TIME_W-1:0] ticks_flat;
    logic [ENTRY_W-1:0]  head_data;
    logic                pop;
    logic [CHAN_W-1:0]   res_channel;
    logic [DIST_W-1:0]   res_distance;
    logic                res_near;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (mer_cfg_index_t'(cfg_addr))
                CFG_MIN_DISTANCE: cfg_next.min_cm  = cfg_wdata;
                CFG_MAX_DISTANCE: cfg_next.max_cm  = cfg_wdata;
                CFG_NEAR_LIMIT:   cfg_next.near_cm = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_cm  <= MIN_DISTANCE_RESET;
            cfg_reg.max_cm  <= MAX_DISTANCE_RESET;
            cfg_reg.near_cm <= NEAR_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !q_status.full;
    assign in_fire  = s_tvalid && s_tready;

    mer_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .echo_levels (s_tdata[LEVEL_W-1:0]),
        .timer_now   (s_tdata[LEVEL_W +: TIME_W]),
        .rearm_mask  (s_tdata[LEVEL_W+TIME_W +: LEVEL_W]),
        .push        (push),
        .done_mask   (done_mask),
        .ticks_flat  (ticks_flat)
    );

    mer_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({ticks_flat, done_mask}),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    mer_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_status.not_empty),
        .head_mask  (head_data[CHANNELS-1:0]),
        .head_ticks (head_data[ENTRY_W-1:CHANNELS]),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_channel  (res_channel),
        .m_distance (res_distance),
        .m_near     (res_near),
        .m_last     (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - CHAN_W - DIST_W - 1){1'b0}},
                      res_near, res_distance, res_channel};

endmodule

>>> rtl/mer_checker.sv
// ----------------------------------------------------------------------------
// Echo ranger checker
// Port-level assertions on the result channel of the echo ranger, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module mer_checker #(
    parameter int CHANNELS = 6
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mer_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import mer_pkg::*;

    // A stalled transaction keeps its valid, data and last marker.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result transaction changed while stalled");

    // Nothing is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The near flag is only raised on a nonzero distance.
    a_near_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CHAN_W+DIST_W] |-> m_tdata[CHAN_W +: DIST_W] != '0)
        else $error("near flag on zero distance");

    // Channel indices stay within the configured number of lines.
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CHAN_W-1:0] < CHANNELS)
        else $error("channel index out of range");

endmodule

bind multi_echo_pulse_ranger mer_checker #(.CHANNELS(CHANNELS)) u_mer_checker (.*);

>>> test/echo_range_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo ranger result checker
// Watches the sample, result and register ports of the echo ranger and keeps
// its own copy of the line state and limits. Every accepted sample yields the
// measurements it completes. Each result transaction is compared field by
// field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module echo_range_checker
    import mer_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIST_W-1:0]     cfg_wdata,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int NUM_LINES   = 6;
    localparam int COUNTER_TOP = 65535;
    localparam int TICKS_PER_US = 2;
    localparam int US_PER_CM   = 58;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [DIST_W-1:0] range_cm;
        logic              near;
        logic              last;
    } range_report_t;

    range_report_t      awaited_reports[$];
    logic [DIST_W-1:0]  min_cm;
    logic [DIST_W-1:0]  max_cm;
    logic [DIST_W-1:0]  near_cm;
    logic [LEVEL_W-1:0] prev_levels;
    logic [LEVEL_W-1:0] armed;
    logic [TIME_W-1:0]  rise_time [NUM_LINES];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic [DIST_W-1:0] echo_distance(input logic [TIME_W-1:0] t0,
                                                        input logic [TIME_W-1:0] t1);
        int ticks;
        int cm;
        if (t1 >= t0) begin
            ticks = int'(t1) - int'(t0);
        end else begin
            ticks = COUNTER_TOP - int'(t0) + int'(t1);
        end
        cm = (ticks / TICKS_PER_US) / US_PER_CM;
        if (cm < int'(min_cm) || cm > int'(max_cm)) begin
            return '0;
        end
        return cm[DIST_W-1:0];
    endfunction

    task automatic predict_sample(input logic [IN_DATA_W-1:0] word);
        logic [LEVEL_W-1:0] lv;
        logic [TIME_W-1:0]  tm;
        logic [LEVEL_W-1:0] rm;
        logic [LEVEL_W-1:0] changed;
        logic [LEVEL_W-1:0] done;
        range_report_t      rep;
        lv = word[LEVEL_W-1:0];
        tm = word[LEVEL_W +: TIME_W];
        rm = word[LEVEL_W+TIME_W +: LEVEL_W];
        armed   = armed & ~rm;
        changed = lv ^ prev_levels;
        done    = changed & ~lv & armed;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (done[i]) begin
                rep.chan     = CHAN_W'(i);
                rep.range_cm = echo_distance(rise_time[i], tm);
                rep.near     = (rep.range_cm != '0) && (rep.range_cm <= near_cm);
                rep.last     = ((done >> (i + 1)) == '0);
                awaited_reports.push_back(rep);
            end
            if (changed[i] && lv[i]) begin
                rise_time[i] = tm;
            end
        end
        armed       = (armed & ~done) | (changed & lv);
        prev_levels = lv;
    endtask

    task automatic check_report();
        range_report_t got;
        range_report_t want;
        got.chan     = m_tdata[CHAN_W-1:0];
        got.range_cm = m_tdata[CHAN_W +: DIST_W];
        got.near     = m_tdata[CHAN_W+DIST_W];
        got.last     = m_tlast;
        if (awaited_reports.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result expected none actual chan=%0d range=%0d %s",
                     $time, got.chan, got.range_cm,
                     $sformatf("near=%0b last=%0b", got.near, got.last));
        end else begin
            want = awaited_reports.pop_front();
            if (got.chan !== want.chan || got.range_cm !== want.range_cm ||
                got.near !== want.near || got.last !== want.last) begin
                fail_count++;
                $display("%0t: mismatch expected chan=%0d range=%0d near=%0b last=%0b %s",
                         $time, want.chan, want.range_cm, want.near, want.last,
                         $sformatf("actual chan=%0d range=%0d near=%0b last=%0b",
                                   got.chan, got.range_cm, got.near, got.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_reports.delete();
            min_cm      = MIN_DISTANCE_RESET;
            max_cm      = MAX_DISTANCE_RESET;
            near_cm     = NEAR_LIMIT_RESET;
            prev_levels = '0;
            armed       = '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                rise_time[i] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                check_report();
            end
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MIN_DISTANCE: min_cm  = cfg_wdata;
                    CFG_MAX_DISTANCE: max_cm  = cfg_wdata;
                    CFG_NEAR_LIMIT:   near_cm = cfg_wdata;
                    default: ;
                endcase
            end
        end
        outstanding = awaited_reports.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Drives echo samples with a wandering tick counter into the ranger, first a
// directed set of pulses covering the distance limits, counter wrap and
// re-arm cases, then random pulse trains under four sets of limits. Both
// stream sides idle at random. The checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import mer_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [DIST_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    logic [TIME_W-1:0]  tick;
    logic [LEVEL_W-1:0] line_levels;

    multi_echo_pulse_ranger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    echo_range_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_sample(input logic [LEVEL_W-1:0] lv, input logic [TIME_W-1:0] tm,
                               input logic [LEVEL_W-1:0] rm);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, rm, tm, lv};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIST_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi,
                              input logic [DIST_W-1:0] nr);
        write_reg(CFG_MIN_DISTANCE, lo);
        write_reg(CFG_MAX_DISTANCE, hi);
        write_reg(CFG_NEAR_LIMIT, nr);
        write_reg(CFG_SPARE, '1);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_pulse_trains(input int count);
        int                 step;
        logic [LEVEL_W-1:0] rm;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0:       step = $urandom_range(0, 150);
                1:       step = $urandom_range(0, 1500);
                2:       step = $urandom_range(0, 12000);
                default: step = $urandom_range(0, 40000);
            endcase
            tick = tick + TIME_W'(step);
            if ($urandom_range(0, 9) == 0) begin
                line_levels = LEVEL_W'($urandom);
            end else begin
                line_levels = line_levels ^ LEVEL_W'($urandom & $urandom);
            end
            rm = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom) : '0;
            push_sample(line_levels, tick, rm);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        tick        = '0;
        line_levels = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 25;
        rx_idle_pct = 62;
        // Every line rises and falls at once: six results of zero length.
        push_sample(6'h3F, 16'd100, 6'h00);
        push_sample(6'h00, 16'd100, 6'h00);
        // Counter wrap, and the longest pulses either side of the wrap.
        push_sample(6'h01, 16'hF000, 6'h00);
        push_sample(6'h00, 16'h1000, 6'h00);
        push_sample(6'h02, 16'h0000, 6'h00);
        push_sample(6'h00, 16'hFFFF, 6'h00);
        push_sample(6'h04, 16'h0001, 6'h00);
        push_sample(6'h00, 16'h0000, 6'h00);
        // Near limit and the edges of the accepted range.
        push_sample(6'h08, 16'd1000, 6'h00);
        push_sample(6'h00, 16'd1580, 6'h00);
        push_sample(6'h10, 16'd2000, 6'h00);
        push_sample(6'h00, 16'd3160, 6'h00);
        push_sample(6'h20, 16'd4000, 6'h00);
        push_sample(6'h00, 16'd5276, 6'h00);
        push_sample(6'h01, 16'd6000, 6'h00);
        push_sample(6'h00, 16'd6232, 6'h00);
        push_sample(6'h02, 16'd7000, 6'h00);
        push_sample(6'h00, 16'd7116, 6'h00);
        push_sample(6'h04, 16'd8000, 6'h00);
        push_sample(6'h00, 16'd54400, 6'h00);
        push_sample(6'h08, 16'd0, 6'h00);
        push_sample(6'h00, 16'd46516, 6'h00);
        // A re-arm beats a falling edge, a fall on an idle line is ignored,
        // and a re-arm with a rising edge starts a fresh measurement.
        push_sample(6'h30, 16'd100, 6'h00);
        push_sample(6'h10, 16'd200, 6'h3F);
        push_sample(6'h01, 16'd300, 6'h01);
        push_sample(6'h00, 16'd400, 6'h00);
        line_levels = '0;
        tick        = 16'd400;
        run_pulse_trains(100);
        wait_drained();

        set_limits(10'd0, 10'd1023, 10'd564);
        tx_idle_pct = 62;
        rx_idle_pct = 25;
        run_pulse_trains(100);
        wait_drained();

        set_limits(10'd500, 10'd100, 10'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_pulse_trains(50);
        wait_drained();

        set_limits(10'd300, 10'd564, 10'd1023);
        run_pulse_trains(70);
        wait_drained();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
